### design/pcni_pkg.sv
package pcni_pkg;

  // Fixed field widths
  localparam int COORD_W  = 16;
  localparam int CFG_W    = 7;
  localparam int INDEX_W  = 18;
  localparam int MAX_DIMS = 3;

  // Internal widths cover the full legal range of cells per side (up to 64)
  localparam int CELL_W = 6;
  localparam int N_W    = 7;

  localparam int MIN_CELLS = 4;

  // Parameter defaults
  localparam int DIMENSIONS_DEF = 3;
  localparam int MAX_CELLS_DEF  = 64;

  // Neighbor offset codes: -1, 0, +1
  localparam logic [1:0] OFF_MINUS = 2'd0;
  localparam logic [1:0] OFF_ZERO  = 2'd1;
  localparam logic [1:0] OFF_PLUS  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_0;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] cell_index;
    logic               last;
  } out_item_t;

  // Home cell of a point in every dimension, with the grid size it used
  typedef struct packed {
    logic [MAX_DIMS-1:0][CELL_W-1:0] home;
    logic [N_W-1:0]                  n;
  } cell_set_t;

  // Index digits, most significant first, padded with zeros on top
  typedef struct packed {
    logic [MAX_DIMS-1:0][CELL_W-1:0] digit;
    logic [N_W-1:0]                  n;
    logic                            last;
  } digit_set_t;

endpackage

### design/pcni_cell_front.sv
module pcni_cell_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcni_pkg::in_item_t  in_data,
  input  logic [pcni_pkg::N_W-1:0] n,
  output logic                out_valid,
  input  logic                out_ready,
  output pcni_pkg::cell_set_t out_cells
);
  import pcni_pkg::*;

  logic                              v1;
  logic [MAX_DIMS-1:0][COORD_W-1:0]  u1;
  logic [N_W-1:0]                    n1;
  logic                              v2;
  cell_set_t                         cells2;
  logic                              ready2;
  logic [MAX_DIMS-1:0][COORD_W-1:0]  u_in;
  logic [MAX_DIMS-1:0][COORD_W+N_W-1:0] prod;

  assign ready2   = !v2 || out_ready;
  assign in_ready = !v1 || ready2;

  // Bias the signed coordinate by half the box: flip the sign bit
  always_comb begin
    u_in[0] = {~in_data.coord_0[COORD_W-1], in_data.coord_0[COORD_W-2:0]};
    u_in[1] = {~in_data.coord_1[COORD_W-1], in_data.coord_1[COORD_W-2:0]};
    u_in[2] = {~in_data.coord_2[COORD_W-1], in_data.coord_2[COORD_W-2:0]};
  end

  // Cell = (u * n) >> 16, exact floor, always below n
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      prod[d] = u1[d] * n1;
    end
  end

  // Stage 1: input register; stage 2: cell register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
    if (in_valid && in_ready) begin
      u1 <= u_in;
      n1 <= n;
    end
    if (v1 && ready2) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        cells2.home[d] <= prod[d][COORD_W +: CELL_W];
      end
      cells2.n <= n1;
    end
  end

  assign out_valid = v2;
  assign out_cells = cells2;

endmodule

### design/pcni_index_pipe.sv
module pcni_index_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcni_pkg::digit_set_t in_digits,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcni_pkg::out_item_t  out_data
);
  import pcni_pkg::*;

  logic                        v4;
  logic [2*CELL_W-1:0]         acc4;
  logic [CELL_W-1:0]           low4;
  logic [N_W-1:0]              n4;
  logic                        last4;
  logic                        v5;
  out_item_t                   out5;
  logic                        ready5;
  logic [CELL_W+N_W-1:0]       mul_hi;
  logic [2*CELL_W-1:0]         acc_next;
  logic [2*CELL_W+N_W-1:0]     idx_full;

  assign ready5   = !v5 || out_ready;
  assign in_ready = !v4 || ready5;

  // First multiply-add: top digit times n plus middle digit
  assign mul_hi   = in_digits.digit[0] * in_digits.n;
  assign acc_next = mul_hi[2*CELL_W-1:0] + {{CELL_W{1'b0}}, in_digits.digit[1]};

  // Second multiply-add: partial index times n plus low digit
  assign idx_full = acc4 * n4 + {{(CELL_W+N_W){1'b0}}, low4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (in_ready) v4 <= in_valid;
      if (ready5) v5 <= v4;
    end
    if (in_valid && in_ready) begin
      acc4  <= acc_next;
      low4  <= in_digits.digit[2];
      n4    <= in_digits.n;
      last4 <= in_digits.last;
    end
    if (v4 && ready5) begin
      out5.cell_index <= idx_full[INDEX_W-1:0];
      out5.last       <= last4;
    end
  end

  assign out_valid = v5;
  assign out_data  = out5;

endmodule

### design/periodic_cell_neighbor_indexer_unit.sv
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_ready  | in_data  (coord_0, coord_1, coord_2)
// out     | out | out_valid / out_ready| out_data (cell_index, last)
// cfg     | in  | cfg_valid / cfg_ready| cfg_data (cells_per_side)
//
// Each point gives 3^DIMENSIONS results (27 at three dimensions), one per cycle;
// the neighbor sequencer emits one index per cycle and takes the next point
// as it emits the last one; results pass front, sequencer and index registers.
// Reset clears all valid bits and sets cells per side to 4.
// A stall on out holds every stage in place; up to two points wait upstream.
module periodic_cell_neighbor_indexer_unit #(
  parameter int DIMENSIONS         = pcni_pkg::DIMENSIONS_DEF,
  parameter int MAX_CELLS_PER_SIDE = pcni_pkg::MAX_CELLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pcni_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pcni_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pcni_pkg::CFG_W-1:0] cfg_data
);
  import pcni_pkg::*;

  localparam int PAD = MAX_DIMS - DIMENSIONS;

  logic [N_W-1:0]   n_reg;
  logic [N_W-1:0]   n_clamped;

  logic             fv;
  logic             f_ready;
  cell_set_t        fcells;

  logic                              v3;
  logic [MAX_DIMS-1:0][2:0][CELL_W-1:0] trip;
  logic [MAX_DIMS-1:0][2:0][CELL_W-1:0] trip_in;
  logic [N_W-1:0]                    n3;
  logic [MAX_DIMS-1:0][1:0]          off;
  logic [MAX_DIMS-1:0][1:0]          off_next;
  logic                              last3;
  logic                              emit;
  logic                              ip_ready;
  logic [MAX_DIMS-1:0][CELL_W-1:0]   g;
  digit_set_t                        digits;
  logic [N_W-1:0]                    nm1;
  logic                              carry;

  // Configuration: grid size, clamped to the legal range on write
  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data < CFG_W'(MIN_CELLS)) begin
      n_clamped = N_W'(MIN_CELLS);
    end else if (cfg_data > CFG_W'(MAX_CELLS_PER_SIDE)) begin
      n_clamped = N_W'(MAX_CELLS_PER_SIDE);
    end else begin
      n_clamped = N_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_reg <= N_W'(MIN_CELLS);
    end else if (cfg_valid && cfg_ready) begin
      n_reg <= n_clamped;
    end
  end

  // Stages 1-2: bias and home cell
  pcni_cell_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .n         (n_reg),
    .out_valid (fv),
    .out_ready (f_ready),
    .out_cells (fcells)
  );

  // Periodic wrap of the three neighbor coordinates per dimension
  assign nm1 = fcells.n - 1'b1;

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      trip_in[d][OFF_MINUS] = (fcells.home[d] == '0) ? nm1[CELL_W-1:0]
                                                     : fcells.home[d] - 1'b1;
      trip_in[d][OFF_ZERO]  = fcells.home[d];
      trip_in[d][OFF_PLUS]  = (fcells.home[d] == nm1[CELL_W-1:0]) ? '0
                                                     : fcells.home[d] + 1'b1;
    end
  end

  // Stage 3: neighbor sequencer, dimension 0 offset steps fastest
  always_comb begin
    last3 = 1'b1;
    for (int d = 0; d < DIMENSIONS; d++) begin
      if (off[d] != OFF_PLUS) last3 = 1'b0;
    end
  end

  always_comb begin
    carry = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      off_next[d] = off[d];
      if (d < DIMENSIONS && carry) begin
        if (off[d] == OFF_PLUS) begin
          off_next[d] = OFF_MINUS;
        end else begin
          off_next[d] = off[d] + 1'b1;
          carry       = 1'b0;
        end
      end
    end
  end

  assign emit    = v3 && ip_ready;
  assign f_ready = !v3 || (emit && last3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3  <= 1'b0;
      off <= {MAX_DIMS{OFF_MINUS}};
    end else begin
      if (f_ready) v3 <= fv;
      if (fv && f_ready) begin
        for (int d = 0; d < MAX_DIMS; d++) off[d] <= OFF_MINUS;
      end else if (emit) begin
        off <= off_next;
      end
    end
    if (fv && f_ready) begin
      trip <= trip_in;
      n3   <= fcells.n;
    end
  end

  // Digits of this neighbor, placed so that the last dimension is the low digit
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      g[d] = trip[d][off[d]];
    end
    for (int j = 0; j < MAX_DIMS; j++) begin
      if (j >= PAD) begin
        digits.digit[j] = g[j - PAD];
      end else begin
        digits.digit[j] = '0;
      end
    end
    digits.n    = n3;
    digits.last = last3;
  end

  // Stages 4-5: mixed-radix index
  pcni_index_pipe u_index (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (ip_ready),
    .in_digits (digits),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### design/pcni_checker.sv
module pcni_checker #(
  parameter int DIMENSIONS         = pcni_pkg::DIMENSIONS_DEF,
  parameter int MAX_CELLS_PER_SIDE = pcni_pkg::MAX_CELLS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input pcni_pkg::in_item_t         in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input pcni_pkg::out_item_t        out_data,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);
  import pcni_pkg::*;

  localparam longint MAX_INDEX = longint'(MAX_CELLS_PER_SIDE) ** DIMENSIONS;

  // A stalled transaction on out holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out transaction changed while stalled");

  // A waiting transaction on in keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("in transaction changed while waiting");

  // Configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("cfg_ready dropped");

  // Every index lies inside the largest grid
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> longint'(out_data.cell_index) < MAX_INDEX)
    else $error("cell_index outside grid");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("out_valid right after reset");

endmodule

bind periodic_cell_neighbor_indexer_unit pcni_checker #(
  .DIMENSIONS         (DIMENSIONS),
  .MAX_CELLS_PER_SIDE (MAX_CELLS_PER_SIDE)
) u_pcni_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

### tb/sv/tb.sv
module tb;
  import pcni_pkg::*;

  localparam int DIMS           = DIMENSIONS_DEF;
  localparam int MAX_N          = MAX_CELLS_DEF;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASE_POINTS   = 30;

  // Expected neighbor indices, built from each accepted point
  class cell_index_board;
    logic [CFG_W-1:0] grid_reg;
    out_item_t        due_q[$];
    int               errors;
    int               checked;

    function new();
      grid_reg = 7'd4;
      errors   = 0;
      checked  = 0;
    endfunction

    // Out-of-range register values are clamped to the legal grid size
    function int grid_n();
      int n;
      n = grid_reg;
      if (n < MIN_CELLS) n = MIN_CELLS;
      if (n > MAX_N) n = MAX_N;
      return n;
    endfunction

    function void note_point(in_item_t p);
      logic [COORD_W-1:0] raw[MAX_DIMS];
      int home[MAX_DIMS];
      int n, total, rem, off, g, idx;
      out_item_t r;
      n = grid_n();
      raw[0] = p.coord_0;
      raw[1] = p.coord_1;
      raw[2] = p.coord_2;
      total = 1;
      // home cell: bias to 0..65535, scale by n, keep the integer part
      for (int d = 0; d < DIMS; d++) begin
        home[d] = ((raw[d] ^ 16'h8000) * n) >> 16;
        total = total * 3;
      end
      // dimension 0 offset steps fastest; dimension 0 is the top index digit
      for (int k = 0; k < total; k++) begin
        rem = k;
        idx = 0;
        for (int d = 0; d < DIMS; d++) begin
          off = rem % 3;
          rem = rem / 3;
          g = (home[d] + n + off - 1) % n;
          idx = idx * n + g;
        end
        r.cell_index = INDEX_W'(idx);
        r.last       = (k == total - 1);
        due_q = {due_q, r};
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_q.size() == 0) begin
        $display("%0t unexpected result: expected none, got index %0d last %0b",
                 $time, got.cell_index, got.last);
        errors++;
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got.cell_index !== want.cell_index) begin
        $display("%0t cell_index mismatch: expected %0d, got %0d",
                 $time, want.cell_index, got.cell_index);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t last mismatch: expected %0b, got %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  cell_index_board board = new();
  bit              burst_mode = 1'b0;
  int              sink_hold  = 0;
  int              quiet      = 0;
  int              points     = 0;
  int              settings   = 0;

  periodic_cell_neighbor_indexer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Result sink: check each transaction, then draw a random stall unless bursting
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold = 0;
    end else if (out_valid && out_ready) begin
      board.check_result(out_data);
      sink_hold = burst_mode ? 0 : $urandom_range(0, 4);
      out_ready <= (sink_hold == 0);
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= (sink_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic wait_drained();
    while (board.due_q.size() != 0) @(posedge clk);
  endtask

  // Valid drops only when a gap is drawn, so back-to-back points keep it high
  task automatic send_point(input in_item_t p);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_point(p);
    points++;
  endtask

  // Register writes only with the pipeline empty
  task automatic set_grid(input logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.grid_reg = v;
    settings++;
  endtask

  // Coordinate right at a cell boundary (or one below it) for the current n
  function automatic logic [COORD_W-1:0] boundary_coord(int n);
    int c, u;
    c = $urandom_range(0, n - 1);
    u = (c * 65536 + n - 1) / n;
    if (u > 0 && $urandom_range(0, 1)) u = u - 1;
    return COORD_W'(u) ^ 16'h8000;
  endfunction

  function automatic in_item_t random_point();
    logic [COORD_W-1:0] c[MAX_DIMS];
    in_item_t p;
    int n;
    n = board.grid_n();
    for (int d = 0; d < MAX_DIMS; d++) begin
      case ($urandom_range(0, 3))
        0: c[d] = 16'h8000 ^ 16'(($urandom_range(0, 1)) ? 16'h7fff : 16'h0000);
        1: c[d] = boundary_coord(n);
        default: c[d] = 16'($urandom);
      endcase
    end
    p.coord_0 = c[0];
    p.coord_1 = c[1];
    p.coord_2 = c[2];
    return p;
  endfunction

  initial begin
    in_item_t         corner[6];
    logic [CFG_W-1:0] edge_grids[3];
    logic [CFG_W-1:0] grids[9];

    // Box corners, center and mixed extremes
    corner[0] = '{coord_2: 16'sh8000, coord_1: 16'sh8000, coord_0: 16'sh8000};
    corner[1] = '{coord_2: 16'sh7fff, coord_1: 16'sh7fff, coord_0: 16'sh7fff};
    corner[2] = '{coord_2: 16'sh0000, coord_1: 16'sh0000, coord_0: 16'sh0000};
    corner[3] = '{coord_2: 16'shffff, coord_1: 16'sh7fff, coord_0: 16'sh8000};
    corner[4] = '{coord_2: 16'shc000, coord_1: 16'sh8000, coord_0: 16'sh7fff};
    corner[5] = '{coord_2: 16'sh8000, coord_1: 16'sh0000, coord_0: 16'shbfff};
    // Largest grid, above-range clamp, zero clamped up to four
    edge_grids = '{7'd64, 7'd127, 7'd0};
    grids = '{7'd5, 7'd3, 7'd64, 7'd37, 7'd4, 7'd127, 7'd1, 7'd63, 7'd0};
    grids[3] = CFG_W'($urandom_range(4, 64));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners at the reset grid, then at each extreme setting
    foreach (corner[i]) send_point(corner[i]);
    foreach (edge_grids[g]) begin
      set_grid(edge_grids[g]);
      foreach (corner[i]) send_point(corner[i]);
    end

    // Random phases; every third phase runs with no idling on either side
    foreach (grids[g]) begin
      set_grid(grids[g]);
      burst_mode = (g % 3 == 2);
      for (int i = 0; i < PHASE_POINTS; i++) begin
        if (i == PHASE_POINTS / 2) begin
          // hold off the sender until the pipeline empties
          in_valid <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
        send_point(random_point());
      end
      burst_mode = 1'b0;
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (board.due_q.size() != 0) begin
      $display("%0t %0d neighbor indices never arrived", $time, board.due_q.size());
      board.errors++;
    end

    $display("Sent %0d points over %0d grid writes (clamped, minimum, maximum and mid sizes);",
             points, settings);
    $display("checked %0d neighbor indices with random stalls and bursts on both sides.",
             board.checked);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
